// File: rtl/core/spmq_pkg.sv
// spmq_pkg: shared types and constants of the stable priority message queue
// action codes, field widths, parameter defaults and the per-cycle control word
// depends on nothing
package spmq_pkg;

  // fixed field widths
  localparam int ACTION_BITS = 2;
  localparam int PRIO_BITS   = 8;
  localparam int TAG_PORT_W  = 16;
  localparam int FILL_BITS   = 5;

  // parameter defaults for the top level
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TAG_BITS    = 16;

  // action codes
  localparam logic [ACTION_BITS-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_POP   = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_CLEAR = 2'd2;

  // control word broadcast to every cell of the row
  typedef struct packed {
    logic                 push;  // push carried out this cycle
    logic                 pop;   // pop this cycle
    logic                 clr;   // clear this cycle
    logic                 ord;   // insert by priority
    logic [PRIO_BITS-1:0] prio;  // priority of the pushed entry
  } ctl_t;

endpackage

// File: rtl/core/spmq_cell.sv
// spmq_cell: one slot of the queue row, holding valid, priority and tag
// takes data from its left or right neighbour or from the broadcast entry
// depends on spmq_pkg
module spmq_cell #(
  parameter int SW = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spmq_pkg::ctl_t                ctl,
  input  logic [SW-1:0]                 new_tag,
  input  logic                          lft_vld,
  input  logic [spmq_pkg::PRIO_BITS-1:0] lft_prio,
  input  logic [SW-1:0]                 lft_tag,
  input  logic                          rgt_vld,
  input  logic [spmq_pkg::PRIO_BITS-1:0] rgt_prio,
  input  logic [SW-1:0]                 rgt_tag,
  input  logic                          taken_in,
  output logic                          taken_out,
  output logic                          vld,
  output logic [spmq_pkg::PRIO_BITS-1:0] prio,
  output logic [SW-1:0]                 tag
);

  logic                           vld_r, vld_nxt;
  logic [spmq_pkg::PRIO_BITS-1:0] prio_r, prio_nxt;
  logic [SW-1:0]                  tag_r, tag_nxt;
  logic                           here;
  logic                           ins;
  logic                           shift;

  // insertion point: first greater entry when ordered, else the first free slot
  assign here      = !vld_r || (ctl.ord && (prio_r > ctl.prio));
  assign taken_out = taken_in || here;
  assign ins       = here && !taken_in;
  assign shift     = taken_in && lft_vld;

  // next slot contents
  always_comb begin
    vld_nxt  = vld_r;
    prio_nxt = prio_r;
    tag_nxt  = tag_r;
    if (ctl.clr) begin
      vld_nxt = 1'b0;
    end else if (ctl.push) begin
      if (ins) begin
        vld_nxt  = 1'b1;
        prio_nxt = ctl.prio;
        tag_nxt  = new_tag;
      end else if (shift) begin
        vld_nxt  = 1'b1;
        prio_nxt = lft_prio;
        tag_nxt  = lft_tag;
      end
    end else if (ctl.pop) begin
      vld_nxt  = rgt_vld;
      prio_nxt = rgt_prio;
      tag_nxt  = rgt_tag;
    end
  end

  // valid flag under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

  assign vld  = vld_r;
  assign prio = prio_r;
  assign tag  = tag_r;

endmodule

// File: rtl/core/stable_priority_message_queue_top.sv
// stable_priority_message_queue_top: bounded stable priority queue as a row of cells
// holds the action decode, fill count and registered result stage
// depends on spmq_pkg and spmq_cell
//
// Usage
//   Input channel in_*: one action per transfer. in_tuser carries the action
//   (push, pop, clear), in_tdata the priority, the ordered flag and the tag.
//   Result channel out_*: exactly one result transfer per action, in order,
//   with the accepted, overflow and popped fields and the fill count after it.
//   Every cell compares its priority with the pushed one and moves its entry
//   left or right in the same cycle, so one action is taken per clock cycle;
//   while the result channel is not stalled; the whole cell row updates at once.
//   The result sits in the output register in the cycle after the transfer.
//   Reset empties the queue and drops any pending result.
//   When the receiver stalls, the held result waits in the output register
//   and in_tready falls until it is taken; the queue state is not touched.
//   A push to a full queue is refused and reported as overflow.
module stable_priority_message_queue_top #(
  parameter int QUEUE_DEPTH = spmq_pkg::DEF_QUEUE_DEPTH,
  parameter int TAG_BITS    = spmq_pkg::DEF_TAG_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] msg_priority, [8] ordered, [24:9] msg_tag, [31:25] zero
  input  logic [31:0] in_tdata,
  // [1:0] action
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] accepted, [1] overflow, [2] popped_valid, [10:3] popped_priority,
  // [26:11] popped_tag, [31:27] fill_count
  output logic [31:0] out_tdata
);

  localparam int PW = spmq_pkg::PRIO_BITS;
  localparam int TW = spmq_pkg::TAG_PORT_W;
  localparam int SW = (TAG_BITS < TW) ? TAG_BITS : TW;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // input fields
  logic [spmq_pkg::ACTION_BITS-1:0] act;
  logic [PW-1:0]                    in_prio;
  logic                             in_ord;
  logic [TW-1:0]                    in_tag;
  logic                             in_acc;

  assign act     = in_tuser;
  assign in_prio = in_tdata[7:0];
  assign in_ord  = in_tdata[8];
  assign in_tag  = in_tdata[24:9];
  assign in_acc  = in_tvalid && in_tready;

  // cell row wiring
  logic            vld   [QUEUE_DEPTH];
  logic [PW-1:0]   prio  [QUEUE_DEPTH];
  logic [SW-1:0]   tag   [QUEUE_DEPTH];
  logic            taken [QUEUE_DEPTH+1];
  spmq_pkg::ctl_t  ctl;
  logic            full;
  logic            empty;

  assign full     = vld[QUEUE_DEPTH-1];
  assign empty    = !vld[0];
  assign taken[0] = 1'b0;

  // action decode
  logic is_push, is_pop, is_clr;
  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    is_clr  = 1'b0;
    unique case (act)
      spmq_pkg::ACT_PUSH:  is_push = 1'b1;
      spmq_pkg::ACT_POP:   is_pop  = 1'b1;
      spmq_pkg::ACT_CLEAR: is_clr  = 1'b1;
      default: ;
    endcase
  end

  assign ctl.push = in_acc && is_push && !full;
  assign ctl.pop  = in_acc && is_pop;
  assign ctl.clr  = in_acc && is_clr;
  assign ctl.ord  = in_ord;
  assign ctl.prio = in_prio;

  // the row of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic          lv, rv;
    logic [PW-1:0] lp, rp;
    logic [SW-1:0] lt, rt;
    if (i == 0) begin : g_head
      assign lv = 1'b0;
      assign lp = '0;
      assign lt = '0;
    end else begin : g_left
      assign lv = vld[i-1];
      assign lp = prio[i-1];
      assign lt = tag[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign rp = '0;
      assign rt = '0;
    end else begin : g_right
      assign rv = vld[i+1];
      assign rp = prio[i+1];
      assign rt = tag[i+1];
    end
    spmq_cell #(
      .SW (SW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_tag   (in_tag[SW-1:0]),
      .lft_vld   (lv),
      .lft_prio  (lp),
      .lft_tag   (lt),
      .rgt_vld   (rv),
      .rgt_prio  (rp),
      .rgt_tag   (rt),
      .taken_in  (taken[i]),
      .taken_out (taken[i+1]),
      .vld       (vld[i]),
      .prio      (prio[i]),
      .tag       (tag[i])
    );
  end

  // fill count
  logic [CW-1:0] cnt_r, cnt_nxt;
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.clr) begin
      cnt_nxt = '0;
    end else if (ctl.push) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (ctl.pop && !empty) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // result fields
  logic            r_acc, r_ovf, r_pv;
  logic [PW-1:0]   r_prio;
  logic [TW-1:0]   r_tag;
  logic [CW+4:0]   cnt_ext;
  logic [31:0]     res;

  assign cnt_ext = {5'b0, cnt_nxt};

  always_comb begin
    r_acc  = ctl.push || ctl.pop || ctl.clr;
    r_ovf  = is_push && full;
    r_pv   = is_pop && !empty;
    r_prio = '0;
    r_tag  = '0;
    if (r_pv) begin
      r_prio         = prio[0];
      r_tag[SW-1:0]  = tag[0];
    end
    res = {cnt_ext[4:0], r_tag, r_prio, r_pv, r_ovf, r_acc};
  end

  // output register, refilled while the held result leaves
  logic        out_vld_r, out_vld_nxt;
  logic [31:0] out_data_r;

  assign in_tready   = !out_vld_r || out_tready;
  assign out_vld_nxt = in_acc || (out_vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // checks
  // a full queue always has its head slot valid
  a_contig: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !empty)
    else $error("queue full while head slot empty");

  // count agrees with the head valid flag
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) == empty)
    else $error("fill count disagrees with head valid");

  // a clear leaves the queue empty
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_clr) |=> empty)
    else $error("queue not empty after clear");

  // a refused push is never marked as carried out
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_data_r[0] && out_data_r[1]))
    else $error("result both accepted and overflow");

  // a held result does not change while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> $stable(out_data_r))
    else $error("stalled result changed");

endmodule
